@@ hdl/colgi_pkg.sv @@
// ----------------------------------------------------------------------------
// colgi_pkg
// Shared widths, constants and types for the gradient colormap interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package colgi_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int POS_W         = FRACTION_BITS + 1;
  localparam int MAX_STOPS     = 16;
  localparam int IDX_W         = $clog2(MAX_STOPS);
  localparam int CNT_W         = 5;
  localparam int CH_W          = 8;
  localparam int NUM_CH        = 4;
  localparam int SMP_W         = 20;
  // c0*d1 + c1*d0 stays below 2^CH_W * span
  localparam int NUM_W         = CH_W + POS_W - 1;
  localparam int DIV_STAGES    = CH_W / 2;

  localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1) << FRACTION_BITS;
  localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_STOPS);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_MAP   = 1'b1;

  // one color stop: position plus channels (0 red, 1 green, 2 blue, 3 alpha)
  typedef struct packed {
    logic [POS_W-1:0]                pos;
    logic [NUM_CH-1:0][CH_W-1:0]     ch;
  } stop_t;

endpackage

`default_nettype wire

@@ hdl/colormap_gradient_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// colormap_gradient_interpolator_core
// Piecewise-linear RGBA colormap over a table of up to 16 color stops.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not stalled; stop writes commit at accept, no result.
// Stages: segment select, span/offsets, multiply-add, four divider stages.
// Reset: rst (sync) clears pipeline valid bits and sets stop_count to 2.
// The stop table is not reset; stops must be written before they are used.
`default_nettype none

module colormap_gradient_interpolator_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [colgi_pkg::CNT_W-1:0]  cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [colgi_pkg::IDX_W-1:0]  stop_index,
  input  wire logic [colgi_pkg::POS_W-1:0]  stop_position,
  input  wire logic [colgi_pkg::CH_W-1:0]   stop_red,
  input  wire logic [colgi_pkg::CH_W-1:0]   stop_green,
  input  wire logic [colgi_pkg::CH_W-1:0]   stop_blue,
  input  wire logic [colgi_pkg::CH_W-1:0]   stop_alpha,
  input  wire logic signed [colgi_pkg::SMP_W-1:0] sample,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [colgi_pkg::CH_W-1:0]   out_red,
  output logic      [colgi_pkg::CH_W-1:0]   out_green,
  output logic      [colgi_pkg::CH_W-1:0]   out_blue,
  output logic      [colgi_pkg::CH_W-1:0]   out_alpha
);

  localparam int NCH = colgi_pkg::NUM_CH;
  localparam int DS  = colgi_pkg::DIV_STAGES;

  logic en;
  logic accept;

  logic [colgi_pkg::CNT_W-1:0] stop_count;
  colgi_pkg::stop_t            stop_table [colgi_pkg::MAX_STOPS];

  // global advance: move whenever the output register is free
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;

  // stop count register, saturated to the legal range on write
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= colgi_pkg::MIN_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < colgi_pkg::MIN_COUNT) begin
        stop_count <= colgi_pkg::MIN_COUNT;
      end else if (cfg_data > colgi_pkg::MAX_COUNT) begin
        stop_count <= colgi_pkg::MAX_COUNT;
      end else begin
        stop_count <= cfg_data;
      end
    end
  end

  // stop write, position saturated to one
  always_ff @(posedge clk) begin
    if (accept && action == colgi_pkg::ACT_WRITE) begin
      stop_table[stop_index].pos <= (stop_position > colgi_pkg::ONE_POS) ?
                                    colgi_pkg::ONE_POS : stop_position;
      stop_table[stop_index].ch  <= {stop_alpha, stop_blue, stop_green, stop_red};
    end
  end

  // ---- stage 0: clamp sample and select segment ----
  logic [colgi_pkg::POS_W-1:0] v0;
  logic [colgi_pkg::IDX_W-1:0] sel;
  logic [colgi_pkg::IDX_W-1:0] last_idx;
  logic                        found;
  logic [colgi_pkg::CNT_W-1:0] count_m1;

  always_comb begin
    if (sample[colgi_pkg::SMP_W-1]) begin
      v0 = '0;
    end else if ($unsigned(sample[colgi_pkg::SMP_W-2:0]) >
                 (colgi_pkg::SMP_W-1)'(colgi_pkg::ONE_POS)) begin
      v0 = colgi_pkg::ONE_POS;
    end else begin
      v0 = sample[colgi_pkg::POS_W-1:0];
    end
    count_m1 = stop_count - colgi_pkg::CNT_W'(1);
    last_idx = count_m1[colgi_pkg::IDX_W-1:0];
    found    = 1'b0;
    sel      = '0;
    // first segment whose upper stop is at or above the sample
    for (int i = colgi_pkg::MAX_STOPS - 2; i >= 0; i--) begin
      if ((colgi_pkg::CNT_W'(i + 1) < stop_count) && (v0 <= stop_table[i + 1].pos)) begin
        found = 1'b1;
        sel   = colgi_pkg::IDX_W'(i);
      end
    end
  end

  logic                        s1_valid;
  logic [colgi_pkg::POS_W-1:0] s1_v;
  colgi_pkg::stop_t            s1_lo;
  colgi_pkg::stop_t            s1_hi;
  logic                        s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid && (action == colgi_pkg::ACT_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v    <= v0;
      s1_lo   <= found ? stop_table[sel] : stop_table[last_idx];
      s1_hi   <= stop_table[sel + colgi_pkg::IDX_W'(1)];
      s1_last <= !found;
    end
  end

  // ---- stage 1: offsets and span; flat cases become c0 / 1 ----
  logic                        bypass;
  logic [colgi_pkg::POS_W-1:0] d0_next;
  logic [colgi_pkg::POS_W-1:0] d1_next;
  logic [colgi_pkg::POS_W-1:0] span_next;

  always_comb begin
    bypass = s1_last || (s1_v <= s1_lo.pos);
    if (bypass) begin
      d1_next   = colgi_pkg::POS_W'(1);
      d0_next   = '0;
      span_next = colgi_pkg::POS_W'(1);
    end else begin
      d1_next   = s1_hi.pos - s1_v;
      d0_next   = s1_v - s1_lo.pos;
      span_next = s1_hi.pos - s1_lo.pos;
    end
  end

  logic                                s2_valid;
  logic [colgi_pkg::POS_W-1:0]         s2_d0;
  logic [colgi_pkg::POS_W-1:0]         s2_d1;
  logic [colgi_pkg::POS_W-1:0]         s2_span;
  logic [NCH-1:0][colgi_pkg::CH_W-1:0] s2_c0;
  logic [NCH-1:0][colgi_pkg::CH_W-1:0] s2_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d0   <= d0_next;
      s2_d1   <= d1_next;
      s2_span <= span_next;
      s2_c0   <= s1_lo.ch;
      s2_c1   <= s1_hi.ch;
    end
  end

  // ---- stage 2: weighted sum per channel ----
  logic                                 s3_valid;
  logic [NCH-1:0][colgi_pkg::NUM_W-1:0] s3_num;
  logic [colgi_pkg::POS_W-1:0]          s3_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        s3_num[c] <= colgi_pkg::NUM_W'(s2_c0[c] * s2_d1) +
                     colgi_pkg::NUM_W'(s2_c1[c] * s2_d0);
      end
      s3_span <= s2_span;
    end
  end

  // ---- divider stages: two quotient bits each ----
  logic [DS:0] dv_valid;
  logic [NCH-1:0][DS:0][colgi_pkg::NUM_W-1:0] dv_rem;
  logic [NCH-1:0][DS:0][colgi_pkg::POS_W-1:0] dv_span;
  logic [NCH-1:0][DS:0][colgi_pkg::CH_W-1:0]  dv_q;

  assign dv_valid[0] = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[DS:1] <= '0;
    end else if (en) begin
      dv_valid[DS:1] <= dv_valid[DS-1:0];
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    assign dv_rem[c][0]  = s3_num[c];
    assign dv_span[c][0] = s3_span;
    assign dv_q[c][0]    = '0;
    for (genvar s = 0; s < DS; s++) begin : g_st
      colgi_div_stage u_div (
        .clk      (clk),
        .en       (en),
        .shift_hi (3'(colgi_pkg::CH_W - 1 - 2 * s)),
        .rem_in   (dv_rem[c][s]),
        .span_in  (dv_span[c][s]),
        .q_in     (dv_q[c][s]),
        .rem_out  (dv_rem[c][s + 1]),
        .span_out (dv_span[c][s + 1]),
        .q_out    (dv_q[c][s + 1])
      );
    end
  end

  // result outputs come straight from the last divider register
  assign out_valid = dv_valid[DS];
  assign out_red   = dv_q[0][DS];
  assign out_green = dv_q[1][DS];
  assign out_blue  = dv_q[2][DS];
  assign out_alpha = dv_q[3][DS];

endmodule

`default_nettype wire

@@ hdl/colgi_div_stage.sv @@
// ----------------------------------------------------------------------------
// colgi_div_stage
// One registered stage of the restoring divider: resolves two quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module colgi_div_stage (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [2:0]                   shift_hi,
  input  wire logic [colgi_pkg::NUM_W-1:0]  rem_in,
  input  wire logic [colgi_pkg::POS_W-1:0]  span_in,
  input  wire logic [colgi_pkg::CH_W-1:0]   q_in,
  output logic      [colgi_pkg::NUM_W-1:0]  rem_out,
  output logic      [colgi_pkg::POS_W-1:0]  span_out,
  output logic      [colgi_pkg::CH_W-1:0]   q_out
);

  logic [colgi_pkg::NUM_W-1:0] d_hi;
  logic [colgi_pkg::NUM_W-1:0] d_lo;
  logic [colgi_pkg::NUM_W-1:0] r1;
  logic [colgi_pkg::NUM_W-1:0] rem_next;
  logic [colgi_pkg::CH_W-1:0]  q_next;
  logic                        ge1;
  logic                        ge2;

  // two trial subtractions of the shifted divisor
  always_comb begin
    d_hi   = colgi_pkg::NUM_W'(span_in) << shift_hi;
    d_lo   = d_hi >> 1;
    ge1    = (rem_in >= d_hi);
    r1     = ge1 ? (rem_in - d_hi) : rem_in;
    ge2    = (r1 >= d_lo);
    rem_next = ge2 ? (r1 - d_lo) : r1;
    q_next = q_in;
    q_next[shift_hi]        = ge1;
    q_next[shift_hi - 3'd1] = ge2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      span_out <= span_in;
      q_out    <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gradient colormap interpolator. Loads stop
// tables, maps directed and random samples, and sweeps stop_count. Each
// result is compared against an in-bench lerp predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [colgi_pkg::CNT_W-1:0]         cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                action;
  logic [colgi_pkg::IDX_W-1:0]         stop_index;
  logic [colgi_pkg::POS_W-1:0]         stop_position;
  logic [colgi_pkg::CH_W-1:0]          stop_red, stop_green, stop_blue, stop_alpha;
  logic signed [colgi_pkg::SMP_W-1:0]  sample;
  logic                                out_valid;
  logic                                out_stall;
  logic [colgi_pkg::CH_W-1:0]          out_red, out_green, out_blue, out_alpha;

  // predictor state
  colgi_pkg::stop_t                    palette [colgi_pkg::MAX_STOPS];
  logic [colgi_pkg::CNT_W-1:0]         active_count;
  logic [4*colgi_pkg::CH_W-1:0]        color_q [$];

  int                  errors;
  bit                  gaps_on;
  int                  hold_cycles;
  int                  quiet_cycles;

  colormap_gradient_interpolator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .stop_index(stop_index), .stop_position(stop_position),
    .stop_red(stop_red), .stop_green(stop_green), .stop_blue(stop_blue),
    .stop_alpha(stop_alpha), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected color for a sample under the current palette
  function automatic logic [4*colgi_pkg::CH_W-1:0] predict_color(
      logic signed [colgi_pkg::SMP_W-1:0] s);
    logic [colgi_pkg::POS_W-1:0]  v;
    int                           n;
    logic [63:0]                  num;
    logic [63:0]                  span;
    logic [4*colgi_pkg::CH_W-1:0] res;
    colgi_pkg::stop_t             lo;
    colgi_pkg::stop_t             hi;
    if (s < 0) v = '0;
    else if (s > $signed({1'b0, colgi_pkg::ONE_POS})) v = colgi_pkg::ONE_POS;
    else v = s[colgi_pkg::POS_W-1:0];
    n = active_count;
    if (n < 2) n = 2;
    if (n > colgi_pkg::MAX_STOPS) n = colgi_pkg::MAX_STOPS;
    for (int i = 0; i + 1 < n; i++) begin
      lo = palette[i];
      hi = palette[i+1];
      if (v <= hi.pos) begin
        for (int k = 0; k < colgi_pkg::NUM_CH; k++) begin
          if (v <= lo.pos) begin
            res[k*colgi_pkg::CH_W +: colgi_pkg::CH_W] = lo.ch[k];
          end else begin
            span = 64'(hi.pos - lo.pos);
            num = 64'(lo.ch[k]) * 64'(hi.pos - v) + 64'(hi.ch[k]) * 64'(v - lo.pos);
            res[k*colgi_pkg::CH_W +: colgi_pkg::CH_W] = 8'(num / span);
          end
        end
        return res;
      end
    end
    for (int k = 0; k < colgi_pkg::NUM_CH; k++)
      res[k*colgi_pkg::CH_W +: colgi_pkg::CH_W] = palette[n-1].ch[k];
    return res;
  endfunction

  // send one request, update the predictor on accept
  task automatic send_request(logic act, logic [colgi_pkg::IDX_W-1:0] idx,
                              logic [colgi_pkg::POS_W-1:0] pos,
                              logic [4*colgi_pkg::CH_W-1:0] rgba,
                              logic signed [colgi_pkg::SMP_W-1:0] smp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    stop_index    <= idx;
    stop_position <= pos;
    stop_red      <= rgba[0*colgi_pkg::CH_W +: colgi_pkg::CH_W];
    stop_green    <= rgba[1*colgi_pkg::CH_W +: colgi_pkg::CH_W];
    stop_blue     <= rgba[2*colgi_pkg::CH_W +: colgi_pkg::CH_W];
    stop_alpha    <= rgba[3*colgi_pkg::CH_W +: colgi_pkg::CH_W];
    sample        <= smp;
    do @(posedge clk); while (in_stall);
    if (act == colgi_pkg::ACT_WRITE) begin
      palette[idx].pos = (pos > colgi_pkg::ONE_POS) ? colgi_pkg::ONE_POS : pos;
      for (int k = 0; k < colgi_pkg::NUM_CH; k++)
        palette[idx].ch[k] = rgba[k*colgi_pkg::CH_W +: colgi_pkg::CH_W];
    end else begin
      color_q.push_back(predict_color(smp));
    end
  endtask

  task automatic write_stop(int idx, logic [colgi_pkg::POS_W-1:0] pos);
    send_request(colgi_pkg::ACT_WRITE, idx[colgi_pkg::IDX_W-1:0], pos, 32'($urandom),
                 colgi_pkg::SMP_W'($urandom));
  endtask

  task automatic map_sample(logic signed [colgi_pkg::SMP_W-1:0] smp);
    send_request(colgi_pkg::ACT_MAP, colgi_pkg::IDX_W'($urandom),
                 colgi_pkg::POS_W'($urandom), 32'($urandom), smp);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // stop_count written only with the pipeline empty
  task automatic set_stop_count(logic [colgi_pkg::CNT_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    active_count  = val;
  endtask

  // random sample: mostly in range, sometimes anywhere
  function automatic logic signed [colgi_pkg::SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return colgi_pkg::SMP_W'($urandom);
      1:       return $urandom_range(0, 4) == 0 ? 20'sd65536 : 20'sd0;
      default: return colgi_pkg::SMP_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic rand_stop_write(int slot);
    if ($urandom_range(0, 3) == 0)
      write_stop(slot, colgi_pkg::POS_W'($urandom));  // unordered, may exceed one
    else
      write_stop(slot, colgi_pkg::POS_W'(slot * 4096 + $urandom_range(0, 4600)));
  endtask

  task automatic test_load_table();
    // ascending table with a zero-width segment and a saturated last stop
    for (int i = 0; i < colgi_pkg::MAX_STOPS; i++) begin
      if (i == 0) write_stop(i, '0);
      else if (i == 5) write_stop(i, palette[4].pos);
      else if (i == 15) write_stop(i, 17'h1FFFF);
      else write_stop(i, colgi_pkg::POS_W'(i * 4300));
    end
    send_request(colgi_pkg::ACT_WRITE, 4'd1, 17'd4300, 32'hFFFF_FFFF, '0);
    send_request(colgi_pkg::ACT_WRITE, 4'd2, 17'd8600, 32'h0000_0000, '0);
  endtask

  task automatic test_directed_maps();
    logic signed [colgi_pkg::SMP_W-1:0] pts [12] = '{-20'sd524288, -20'sd1, 20'sd0,
      20'sd1, 20'sd4300, 20'sd6000, 20'sd17200, 20'sd32768, 20'sd65535, 20'sd65536,
      20'sd65537, 20'sd524287};
    foreach (pts[i]) map_sample(pts[i]);
    set_stop_count(colgi_pkg::CNT_W'(16));
    foreach (pts[i]) map_sample(pts[i]);
  endtask

  task automatic test_count_sweep();
    logic [colgi_pkg::CNT_W-1:0] counts [8] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd9, 5'd16,
                                                5'd17, 5'd31};
    foreach (counts[c]) begin
      set_stop_count(counts[c]);
      repeat (15) map_sample(rand_sample());
    end
  endtask

  task automatic test_random_mix(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        rand_stop_write($urandom_range(0, colgi_pkg::MAX_STOPS-1));
      else
        map_sample(rand_sample());
    end
  endtask

  // receiver blocks for a long stretch while requests keep coming
  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_cycles = 40;
    gaps_on = 1'b0;
    repeat (30) map_sample(rand_sample());
    gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    drain();
    repeat (10) map_sample(rand_sample());
  endtask

  // result checker and receiver stall pattern
  int burst_left;
  always @(posedge clk) begin
    logic [4*colgi_pkg::CH_W-1:0] exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        $error("unexpected result %h%h%h%h", out_red, out_green, out_blue, out_alpha);
        errors++;
      end else begin
        exp_c = color_q.pop_front();
        if (out_red !== exp_c[0*colgi_pkg::CH_W +: colgi_pkg::CH_W]) begin
          $error("out_red exp %0d got %0d",
                 exp_c[0*colgi_pkg::CH_W +: colgi_pkg::CH_W], out_red);
          errors++;
        end
        if (out_green !== exp_c[1*colgi_pkg::CH_W +: colgi_pkg::CH_W]) begin
          $error("out_green exp %0d got %0d",
                 exp_c[1*colgi_pkg::CH_W +: colgi_pkg::CH_W], out_green);
          errors++;
        end
        if (out_blue !== exp_c[2*colgi_pkg::CH_W +: colgi_pkg::CH_W]) begin
          $error("out_blue exp %0d got %0d",
                 exp_c[2*colgi_pkg::CH_W +: colgi_pkg::CH_W], out_blue);
          errors++;
        end
        if (out_alpha !== exp_c[3*colgi_pkg::CH_W +: colgi_pkg::CH_W]) begin
          $error("out_alpha exp %0d got %0d",
                 exp_c[3*colgi_pkg::CH_W +: colgi_pkg::CH_W], out_alpha);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    burst_left = 0;
    quiet_cycles = 0;
    active_count = colgi_pkg::MIN_COUNT;
    for (int i = 0; i < colgi_pkg::MAX_STOPS; i++) palette[i] = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = colgi_pkg::ACT_WRITE;
    stop_index = '0;
    stop_position = '0;
    stop_red = '0; stop_green = '0; stop_blue = '0; stop_alpha = '0;
    sample = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_table();
    test_directed_maps();
    test_count_sweep();
    test_random_mix(225);
    test_backpressure();
    test_sender_pause();
    set_stop_count(colgi_pkg::CNT_W'($urandom_range(2, 16)));
    test_random_mix(225);
    gaps_on = 1'b0;
    test_random_mix(100);

    drain();
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/colgi_pkg.sv
hdl/colgi_div_stage.sv
hdl/colormap_gradient_interpolator_core.sv
dv/tb.sv
